// ----- design/nmea_line_checksum_checker_macros.svh -----
// Assertion helpers for the sentence checker.
`ifndef NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NLCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NLCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/nlcc_pkg.sv -----
package nlcc_pkg;

  localparam int unsigned LINE_CAPACITY = 96;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned OUT_TDATA_W   = 24;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GGA   = 2'd2
  } nlcc_kind_t;

  typedef struct packed {
    logic [7:0]       computed_sum;
    logic [LEN_W-1:0] line_length;
    nlcc_kind_t       sentence_kind;
    logic             sentence_ok;
  } nlcc_result_t;

  // Returns {bad, value}; bad is set for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- design/nlcc_in_reg.sv -----
module nlcc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte
);
  import nlcc_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

endmodule

// ----- design/nlcc_line_state.sv -----
module nlcc_line_state (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            in_byte,
  output logic                  res_valid,
  output nlcc_pkg::nlcc_result_t res
);
  import nlcc_pkg::*;

  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic             starts_with_dollar, starts_with_dollar_next;
  logic             star_found, star_found_next;
  logic [LEN_W-1:0] star_index, star_index_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       first_hex_char, first_hex_char_next;
  logic [7:0]       second_hex_char, second_hex_char_next;
  logic [15:0]      recent_chars, recent_chars_next;
  logic             rmc_found, rmc_found_next;
  logic             gga_found, gga_found_next;
  logic             text_ended, text_ended_next;

  logic       is_term;
  logic       clear;
  logic [4:0] hi, lo;
  logic [LEN_W:0] star_pos3, star_pos1, star_pos2, count_ext;
  logic       ok;

  assign is_term   = (in_byte == CH_LF) || (in_byte == CH_CR);
  assign hi        = hex_value(first_hex_char);
  assign lo        = hex_value(second_hex_char);
  assign count_ext = {1'b0, byte_count};
  assign star_pos1 = {1'b0, star_index} + (LEN_W+1)'(1);
  assign star_pos2 = {1'b0, star_index} + (LEN_W+1)'(2);
  assign star_pos3 = {1'b0, star_index} + (LEN_W+1)'(3);

  assign ok = (byte_count >= LEN_W'(4)) && starts_with_dollar && star_found &&
              (star_pos3 <= count_ext) && !hi[4] && !lo[4] &&
              (running_xor == {hi[3:0], lo[3:0]});

  assign res_valid = advance && is_term && (byte_count != '0);

  always_comb begin
    res.sentence_ok   = ok;
    res.sentence_kind = KIND_OTHER;
    if (ok && rmc_found) begin
      res.sentence_kind = KIND_RMC;
    end else if (ok && gga_found) begin
      res.sentence_kind = KIND_GGA;
    end
    res.line_length  = byte_count;
    res.computed_sum = running_xor;
  end

  always_comb begin
    byte_count_next         = byte_count;
    starts_with_dollar_next = starts_with_dollar;
    star_found_next         = star_found;
    star_index_next         = star_index;
    running_xor_next        = running_xor;
    first_hex_char_next     = first_hex_char;
    second_hex_char_next    = second_hex_char;
    recent_chars_next       = recent_chars;
    rmc_found_next          = rmc_found;
    gga_found_next          = gga_found;
    text_ended_next         = text_ended;
    // A terminator or an overflow clears the line state.
    clear = is_term || (byte_count >= LEN_LIMIT);

    if (!clear) begin
      if (byte_count == '0) begin
        starts_with_dollar_next = (in_byte == CH_DOLLAR);
      end
      if (!star_found) begin
        if (in_byte == CH_STAR) begin
          star_found_next = 1'b1;
          star_index_next = byte_count;
        end else if (byte_count != '0) begin
          running_xor_next = running_xor ^ in_byte;
        end
      end else begin
        if (count_ext == star_pos1) first_hex_char_next  = in_byte;
        if (count_ext == star_pos2) second_hex_char_next = in_byte;
      end
      if (!text_ended) begin
        if (in_byte == CH_STAR || in_byte == CH_NUL) begin
          text_ended_next = 1'b1;
        end else begin
          if (recent_chars == {CH_R, CH_M} && in_byte == CH_C) rmc_found_next = 1'b1;
          if (recent_chars == {CH_G, CH_G} && in_byte == CH_A) gga_found_next = 1'b1;
          recent_chars_next = {recent_chars[7:0], in_byte};
        end
      end
      byte_count_next = byte_count + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && clear)) begin
      byte_count         <= '0;
      starts_with_dollar <= 1'b0;
      star_found         <= 1'b0;
      star_index         <= '0;
      running_xor        <= '0;
      first_hex_char     <= '0;
      second_hex_char    <= '0;
      recent_chars       <= '0;
      rmc_found          <= 1'b0;
      gga_found          <= 1'b0;
      text_ended         <= 1'b0;
    end else if (advance) begin
      byte_count         <= byte_count_next;
      starts_with_dollar <= starts_with_dollar_next;
      star_found         <= star_found_next;
      star_index         <= star_index_next;
      running_xor        <= running_xor_next;
      first_hex_char     <= first_hex_char_next;
      second_hex_char    <= second_hex_char_next;
      recent_chars       <= recent_chars_next;
      rmc_found          <= rmc_found_next;
      gga_found          <= gga_found_next;
      text_ended         <= text_ended_next;
    end
  end

endmodule

// ----- design/nlcc_out_reg.sv -----
module nlcc_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  nlcc_pkg::nlcc_result_t         res,
  output logic                           out_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [nlcc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import nlcc_pkg::*;

  nlcc_result_t held;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {(OUT_TDATA_W - $bits(nlcc_result_t))'(0), held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ----- design/nmea_line_checksum_checker.sv -----
// An accepted byte is held in the input register; the result of a line-ending byte
// is loaded into the output register and shown on the master side. Throughput:
// one byte per cycle while the output is free; the line update is one combinational
// pass between the input register and the line state and result registers.
// Reset (rst, synchronous, active high) empties both registers and clears the line.
`include "nmea_line_checksum_checker_macros.svh"

module nmea_line_checksum_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] sentence_ok, [2:1] sentence_kind, [9:3] line_length,
  // [17:10] computed_sum, [23:18] zero
  output logic [nlcc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import nlcc_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  logic         out_free;
  logic         res_valid;
  nlcc_result_t res;

  // Hold the byte while a finished result still waits downstream.
  assign advance = in_valid && out_free;

  nlcc_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  nlcc_line_state u_line (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  nlcc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `NLCC_ASSERT_NOW(a_kind_needs_ok, clk, rst, m_tvalid && (m_tdata[2:1] != 2'd0), m_tdata[0], "kind reported on a failing line")
  `NLCC_ASSERT_NOW(a_len_range, clk, rst, m_tvalid, (m_tdata[9:3] != 7'd0) && (m_tdata[9:3] <= LEN_LIMIT), "line length out of range")
  `NLCC_ASSERT_NOW(a_no_load_when_full, clk, rst, res_valid, out_free, "result produced while output is occupied")
  `NLCC_ASSERT_NEXT(a_load_shows, clk, rst, res_valid, m_tvalid, "loaded result not presented")

endmodule
